>>> rtl/core/ntt_pkg.sv
// Shared types, constants and the helper function of the NAT translation table.
`default_nettype none

package ntt_pkg;

  // Default table geometry.
  localparam int unsigned NttEntries = 16;
  localparam int unsigned NttLinks   = 4;

  // Register reset values.
  localparam logic [31:0] OuterAddrRst  = 32'hB848_68DD;
  localparam logic [15:0] EstTimeoutRst = 16'd7440;
  localparam logic [15:0] TrnTimeoutRst = 16'd300;
  localparam logic [15:0] IcmpTimeoutRst = 16'd60;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegOuterAddr  = 2'd0;
  localparam logic [1:0] RegEstTimeout = 2'd1;
  localparam logic [1:0] RegTrnTimeout = 2'd2;
  localparam logic [1:0] RegIcmpTimeout = 2'd3;

  typedef enum logic [1:0] {
    OP_TCP  = 2'd0,
    OP_ICMP = 2'd1,
    OP_TICK = 2'd2
  } opcode_e;

  // Connection phase codes.
  localparam logic [2:0] PhSynSent = 3'd1;
  localparam logic [2:0] PhSynRcvd = 3'd2;
  localparam logic [2:0] PhEstab   = 3'd3;
  localparam logic [2:0] PhClosing = 3'd4;

  // TCP flag bit positions.
  localparam int unsigned FlagFin = 0;
  localparam int unsigned FlagSyn = 1;
  localparam int unsigned FlagRst = 2;

  typedef struct packed {
    logic [31:0] outer_address;
    logic [15:0] established_timeout;
    logic [15:0] transitory_timeout;
    logic [15:0] icmp_entry_timeout;
  } cfg_t;

  typedef struct packed {
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [2:0]  phase;
    logic [31:0] stamp;
  } link_t;

  typedef struct packed {
    logic load;
    logic scan_ent;
    logic ent_inc;
    logic k_clr;
    logic k_inc;
    logic decide;
    logic link_eval;
    logic link_act;
    logic tick_inc;
    logic tick_ent;
    logic tick_link;
    logic tick_end;
    logic res_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_pkt;
    logic is_tick;
    logic ent_last;
    logic k_last;
    logic go_link;
    logic tcp_ent;
    logic link_live;
  } ctrl_stat_t;

  // Next phase of a connection that a packet hits.
  function automatic logic [2:0] next_phase(input logic [2:0] ph, input logic [7:0] flags,
                                            input logic outbound);
    logic [2:0] res;
    res = ph;
    if (flags[FlagRst]) begin
      res = ph;
    end else if (flags[FlagFin]) begin
      res = PhClosing;
    end else if (flags[FlagSyn]) begin
      if (ph == PhEstab || ph == PhClosing) begin
        res = ph;
      end else if (outbound) begin
        res = (ph != PhSynRcvd) ? PhSynSent : ph;
      end else begin
        res = PhSynRcvd;
      end
    end else if (ph == PhSynRcvd) begin
      res = PhEstab;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ntt_ctrl.sv
// Sequencer of the NAT translation table: walks entries and connections.
`default_nettype none

module ntt_ctrl
  import ntt_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ESCAN, S_DECIDE, S_LREAD, S_LCHECK, S_LACT,
    S_TINC, S_TENT, S_TLREAD, S_TLCHECK, S_TEND, S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.is_pkt) state_d = S_ESCAN;
        else if (stat_i.is_tick) state_d = S_TINC;
        else state_d = S_RESULT;
      end
      S_ESCAN: begin
        cmd_o.scan_ent = 1'b1;
        if (stat_i.ent_last) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (stat_i.go_link) begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_LREAD;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_LREAD: state_d = S_LCHECK;
      S_LCHECK: begin
        cmd_o.link_eval = 1'b1;
        cmd_o.k_inc     = 1'b1;
        state_d         = stat_i.k_last ? S_LACT : S_LREAD;
      end
      S_LACT: begin
        cmd_o.link_act = 1'b1;
        state_d        = S_RESULT;
      end
      S_TINC: begin
        cmd_o.tick_inc = 1'b1;
        state_d        = S_TENT;
      end
      S_TENT: begin
        cmd_o.tick_ent = 1'b1;
        if (stat_i.tcp_ent) begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_TLREAD;
        end else begin
          cmd_o.ent_inc = 1'b1;
          if (stat_i.ent_last) state_d = S_RESULT;
        end
      end
      S_TLREAD: begin
        if (!stat_i.link_live) begin
          cmd_o.k_inc = 1'b1;
          if (stat_i.k_last) state_d = S_TEND;
        end else begin
          state_d = S_TLCHECK;
        end
      end
      S_TLCHECK: begin
        cmd_o.tick_link = 1'b1;
        cmd_o.k_inc     = 1'b1;
        state_d         = stat_i.k_last ? S_TEND : S_TLREAD;
      end
      S_TEND: begin
        cmd_o.tick_end = 1'b1;
        cmd_o.ent_inc  = 1'b1;
        state_d        = stat_i.ent_last ? S_RESULT : S_TENT;
      end
      S_RESULT: begin
        cmd_o.res_out = 1'b1;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.res_out;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> rtl/core/ntt_dp.sv
// Datapath of the NAT translation table: entry store, connection memory, trackers.
`default_nettype none

module ntt_dp
  import ntt_pkg::*;
#(
  parameter int unsigned ENTRIES         = NttEntries,
  parameter int unsigned LINKS_PER_ENTRY = NttLinks
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output ctrl_stat_t  stat_o,
  input  cfg_t        cfg_i,
  input  wire  [1:0]  opcode_i,
  input  wire         outbound_i,
  input  wire  [31:0] source_address_i,
  input  wire  [31:0] dest_address_i,
  input  wire  [15:0] source_port_i,
  input  wire  [15:0] dest_port_i,
  input  wire  [7:0]  tcp_flag_bits_i,
  output logic        forward_o,
  output logic [31:0] rewritten_address_o,
  output logic [15:0] rewritten_port_o,
  output logic        table_full_o
);

  localparam int unsigned EW    = $clog2(ENTRIES);
  localparam int unsigned LW    = (LINKS_PER_ENTRY > 1) ? $clog2(LINKS_PER_ENTRY) : 1;
  localparam int unsigned SLOTS = ENTRIES * LINKS_PER_ENTRY;
  localparam int unsigned SW    = $clog2(SLOTS);

  // Latched item.
  logic [1:0]  op_q;
  logic        out_q;
  logic [31:0] saddr_q, daddr_q;
  logic [15:0] sport_q, dport_q;
  logic [7:0]  flags_q;

  logic [31:0] now_q, serial_q;

  // Entry store.
  logic        ent_vld_q    [ENTRIES];
  logic        ent_tcp_q    [ENTRIES];
  logic [31:0] ent_iaddr_q  [ENTRIES];
  logic [15:0] ent_iport_q  [ENTRIES];
  logic [15:0] ent_oport_q  [ENTRIES];
  logic [31:0] ent_stamp_q  [ENTRIES];
  logic [31:0] ent_serial_q [ENTRIES];

  // Connection store; the valid bits are kept as one word per entry.
  logic [LINKS_PER_ENTRY-1:0] lnk_vld_q [ENTRIES];
  link_t lnk_mem   [SLOTS];
  link_t lnk_rd_q;

  logic [EW-1:0] ent_q, lent_q;
  logic [LW-1:0] k_q;

  // Search trackers.
  logic          best_v_q, free_v_q;
  logic [EW-1:0] best_idx_q, free_idx_q;
  logic [31:0]   best_age_q, best_iaddr_q;
  logic [15:0]   best_iport_q, best_oport_q;
  logic          m_v_q, lf_v_q;
  logic [LW-1:0] m_k_q, lf_k_q;
  logic [2:0]    m_ph_q;

  logic        fwd_q, full_q;
  logic [31:0] res_addr_q;
  logic [15:0] res_port_q;

  logic          is_tcp_op, is_icmp_op, syn;
  logic [15:0]   key_port;
  logic          ent_hit;
  logic [31:0]   cur_age, ent_idle, lnk_idle;
  logic [15:0]   lnk_lim;
  logic [SW-1:0] slot, slot0, slot_new, slot_match;
  logic          link_live, grp_any;
  logic [31:0]   pk_addr;
  logic [15:0]   pk_port;
  logic          dec_need, dec_create, dec_full, lact_new, lact_full;
  logic          lw_en;
  logic [SW-1:0] lw_addr;
  link_t         lw_data;
  logic          ent_last;

  assign is_tcp_op  = (op_q == OP_TCP);
  assign is_icmp_op = (op_q == OP_ICMP);
  assign syn        = flags_q[FlagSyn];
  assign key_port   = (!out_q && is_tcp_op) ? dport_q : sport_q;
  assign pk_addr    = out_q ? daddr_q : saddr_q;
  assign pk_port    = out_q ? dport_q : sport_q;
  assign ent_last   = (ent_q == EW'(ENTRIES - 1));

  assign ent_hit = ent_vld_q[ent_q] && (ent_tcp_q[ent_q] == is_tcp_op) &&
                   (out_q ? (ent_iaddr_q[ent_q] == saddr_q && ent_iport_q[ent_q] == sport_q)
                          : (ent_oport_q[ent_q] == key_port));
  assign cur_age  = serial_q - ent_serial_q[ent_q];
  assign ent_idle = now_q - ent_stamp_q[ent_q];
  assign lnk_idle = now_q - lnk_rd_q.stamp;
  assign lnk_lim  = (lnk_rd_q.phase == PhEstab) ? cfg_i.established_timeout
                                                : cfg_i.transitory_timeout;

  assign slot       = SW'(int'(lent_q) * int'(LINKS_PER_ENTRY) + int'(k_q));
  assign slot0      = SW'(int'(free_idx_q) * int'(LINKS_PER_ENTRY));
  assign slot_new   = SW'(int'(lent_q) * int'(LINKS_PER_ENTRY) + int'(lf_k_q));
  assign slot_match = SW'(int'(lent_q) * int'(LINKS_PER_ENTRY) + int'(m_k_q));
  assign link_live  = lnk_vld_q[lent_q][k_q];
  assign grp_any    = |lnk_vld_q[ent_q];

  // An unmatched outbound ICMP packet or TCP SYN needs a new entry.
  assign dec_need   = !best_v_q && out_q && (is_icmp_op || (is_tcp_op && syn));
  assign dec_create = cmd_i.decide && dec_need && free_v_q;
  assign dec_full   = dec_need && !free_v_q;
  assign lact_new   = !m_v_q && out_q && syn;
  assign lact_full  = lact_new && !lf_v_q;

  always_comb begin
    lw_en   = 1'b0;
    lw_addr = slot0;
    lw_data = '{peer_addr: daddr_q, peer_port: dport_q, phase: PhSynSent, stamp: now_q};
    if (dec_create && is_tcp_op) begin
      lw_en = 1'b1;
    end else if (cmd_i.link_act && lact_new && lf_v_q) begin
      lw_en   = 1'b1;
      lw_addr = slot_new;
    end else if (cmd_i.link_act && m_v_q) begin
      lw_en   = 1'b1;
      lw_addr = slot_match;
      lw_data = '{peer_addr: pk_addr, peer_port: pk_port,
                  phase: next_phase(m_ph_q, flags_q, out_q), stamp: now_q};
    end
  end

  // Connection memory with registered read.
  always_ff @(posedge clk_i) begin
    if (lw_en) lnk_mem[lw_addr] <= lw_data;
    lnk_rd_q <= lnk_mem[slot];
  end

  // Item latch and payload trackers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      out_q   <= outbound_i;
      saddr_q <= source_address_i;
      daddr_q <= dest_address_i;
      sport_q <= source_port_i;
      dport_q <= dest_port_i;
      flags_q <= tcp_flag_bits_i;
    end
    if (cmd_i.scan_ent && ent_hit && (!best_v_q || cur_age < best_age_q)) begin
      best_idx_q   <= ent_q;
      best_age_q   <= cur_age;
      best_iaddr_q <= ent_iaddr_q[ent_q];
      best_iport_q <= ent_iport_q[ent_q];
      best_oport_q <= ent_oport_q[ent_q];
    end
    if (cmd_i.scan_ent && !ent_vld_q[ent_q] && !free_v_q) free_idx_q <= ent_q;
    if (cmd_i.link_eval && link_live && !m_v_q &&
        lnk_rd_q.peer_addr == pk_addr && lnk_rd_q.peer_port == pk_port) begin
      m_k_q  <= k_q;
      m_ph_q <= lnk_rd_q.phase;
    end
    if (cmd_i.link_eval && !link_live && !lf_v_q) lf_k_q <= k_q;
    if (cmd_i.decide) begin
      res_addr_q <= out_q ? cfg_i.outer_address : best_iaddr_q;
      res_port_q <= out_q ? (best_v_q ? best_oport_q : sport_q) : best_iport_q;
    end
    if (cmd_i.res_out) begin
      rewritten_address_o <= fwd_q ? res_addr_q : '0;
      rewritten_port_o    <= fwd_q ? res_port_q : '0;
    end
  end

  // Control state and the stores' valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      serial_q     <= '0;
      ent_q        <= '0;
      lent_q       <= '0;
      k_q          <= '0;
      best_v_q     <= 1'b0;
      free_v_q     <= 1'b0;
      m_v_q        <= 1'b0;
      lf_v_q       <= 1'b0;
      fwd_q        <= 1'b0;
      full_q       <= 1'b0;
      forward_o    <= 1'b0;
      table_full_o <= 1'b0;
      for (int e = 0; e < int'(ENTRIES); e++) begin
        ent_vld_q[e] <= 1'b0;
        lnk_vld_q[e] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        ent_q    <= '0;
        best_v_q <= 1'b0;
        free_v_q <= 1'b0;
        fwd_q    <= 1'b0;
        full_q   <= 1'b0;
      end
      if (cmd_i.scan_ent || cmd_i.ent_inc) ent_q <= ent_last ? '0 : ent_q + 1'b1;
      if (cmd_i.scan_ent && ent_hit && (!best_v_q || cur_age < best_age_q)) best_v_q <= 1'b1;
      if (cmd_i.scan_ent && !ent_vld_q[ent_q]) free_v_q <= 1'b1;
      if (cmd_i.k_clr) begin
        k_q    <= '0;
        m_v_q  <= 1'b0;
        lf_v_q <= 1'b0;
      end
      if (cmd_i.k_inc) k_q <= k_q + 1'b1;
      if (cmd_i.link_eval && link_live && lnk_rd_q.peer_addr == pk_addr &&
          lnk_rd_q.peer_port == pk_port) m_v_q <= 1'b1;
      if (cmd_i.link_eval && !link_live) lf_v_q <= 1'b1;

      if (cmd_i.decide) begin
        lent_q <= best_idx_q;
        fwd_q  <= dec_create || (is_icmp_op && best_v_q);
        full_q <= dec_full;
        if (is_icmp_op && best_v_q) ent_stamp_q[best_idx_q] <= now_q;
      end
      if (dec_create) begin
        ent_vld_q[free_idx_q]    <= 1'b1;
        ent_tcp_q[free_idx_q]    <= is_tcp_op;
        ent_iaddr_q[free_idx_q]  <= saddr_q;
        ent_iport_q[free_idx_q]  <= sport_q;
        ent_oport_q[free_idx_q]  <= sport_q;
        ent_stamp_q[free_idx_q]  <= now_q;
        ent_serial_q[free_idx_q] <= serial_q;
        serial_q                 <= serial_q + 1'b1;
        // A new TCP entry starts with its first connection in slot zero.
        lnk_vld_q[free_idx_q]    <= is_tcp_op ? LINKS_PER_ENTRY'(1) : '0;
      end
      if (cmd_i.link_act) begin
        fwd_q  <= !lact_full;
        full_q <= lact_full;
        if (!lact_full) ent_stamp_q[lent_q] <= now_q;
        if (lact_new && lf_v_q) lnk_vld_q[lent_q][lf_k_q] <= 1'b1;
      end

      if (cmd_i.tick_inc) begin
        now_q <= now_q + 1'b1;
        ent_q <= '0;
      end
      if (cmd_i.tick_ent) begin
        lent_q <= ent_q;
        if (ent_vld_q[ent_q] && !ent_tcp_q[ent_q] &&
            ent_idle >= {16'd0, cfg_i.icmp_entry_timeout}) ent_vld_q[ent_q] <= 1'b0;
      end
      if (cmd_i.tick_link && lnk_idle >= {16'd0, lnk_lim}) lnk_vld_q[lent_q][k_q] <= 1'b0;
      if (cmd_i.tick_end && !grp_any) ent_vld_q[ent_q] <= 1'b0;

      if (cmd_i.res_out) begin
        forward_o    <= fwd_q;
        table_full_o <= full_q;
      end
    end
  end

  assign stat_o = '{
    is_pkt:    is_tcp_op || is_icmp_op,
    is_tick:   (op_q == OP_TICK),
    ent_last:  ent_last,
    k_last:    (k_q == LW'(LINKS_PER_ENTRY - 1)),
    go_link:   is_tcp_op && best_v_q,
    tcp_ent:   ent_vld_q[ent_q] && ent_tcp_q[ent_q],
    link_live: link_live
  };

endmodule

`default_nettype wire

>>> rtl/core/nat_translation_table.sv
// Top level of the NAT translation table: register port, sequencer and datapath.
`default_nettype none

// Channel        Ports                                        Transaction taken when
// item in        start, busy, opcode_i .. tcp_flag_bits_i     start high and busy low
// result out     result_valid_o, forward_o .. table_full_o    every cycle result_valid_o is high
// registers      psel, penable, pwrite, paddr, pwdata, prdata psel, penable, pwrite, pready high
//
// A packet's result follows a sweep over all entries; a TCP packet that hits an entry
// adds a walk over that entry's connection memory. A tick sweeps all entries and walks
// the connections of every TCP entry through the one-port connection memory with
// registered read.
// busy drops in the cycle the result is shown, so the next item may enter then.
// Reset empties the table at once through valid bits; there is no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.

module nat_translation_table
  import ntt_pkg::*;
#(
  parameter int unsigned ENTRIES         = NttEntries,
  parameter int unsigned LINKS_PER_ENTRY = NttLinks
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  opcode_i,
  input  wire         outbound_i,
  input  wire  [31:0] source_address_i,
  input  wire  [31:0] dest_address_i,
  input  wire  [15:0] source_port_i,
  input  wire  [15:0] dest_port_i,
  input  wire  [7:0]  tcp_flag_bits_i,
  output logic        result_valid_o,
  output logic        forward_o,
  output logic [31:0] rewritten_address_o,
  output logic [15:0] rewritten_port_o,
  output logic        table_full_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_q;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       wr_en;
  logic [1:0] reg_idx;

  // Registers are word aligned; the low two address bits are ignored.
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.outer_address       <= OuterAddrRst;
      cfg_q.established_timeout <= EstTimeoutRst;
      cfg_q.transitory_timeout  <= TrnTimeoutRst;
      cfg_q.icmp_entry_timeout  <= IcmpTimeoutRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegOuterAddr:   cfg_q.outer_address       <= pwdata;
        RegEstTimeout:  cfg_q.established_timeout <= pwdata[15:0];
        RegTrnTimeout:  cfg_q.transitory_timeout  <= pwdata[15:0];
        RegIcmpTimeout: cfg_q.icmp_entry_timeout  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegOuterAddr:   prdata = cfg_q.outer_address;
      RegEstTimeout:  prdata = {16'd0, cfg_q.established_timeout};
      RegTrnTimeout:  prdata = {16'd0, cfg_q.transitory_timeout};
      RegIcmpTimeout: prdata = {16'd0, cfg_q.icmp_entry_timeout};
      default:        prdata = '0;
    endcase
  end

  // The sequencer decides the order of entry and connection visits.
  ntt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (result_valid_o)
  );

  // The datapath holds the tables and builds the result transaction.
  ntt_dp #(
    .ENTRIES        (ENTRIES),
    .LINKS_PER_ENTRY(LINKS_PER_ENTRY)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_i              (cfg_q),
    .opcode_i           (opcode_i),
    .outbound_i         (outbound_i),
    .source_address_i   (source_address_i),
    .dest_address_i     (dest_address_i),
    .source_port_i      (source_port_i),
    .dest_port_i        (dest_port_i),
    .tcp_flag_bits_i    (tcp_flag_bits_i),
    .forward_o          (forward_o),
    .rewritten_address_o(rewritten_address_o),
    .rewritten_port_o   (rewritten_port_o),
    .table_full_o       (table_full_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/ntt_checker.sv
// Port-level checks of the NAT translation table and their binding.
`default_nettype none

module ntt_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        start,
  input wire        busy,
  input wire        result_valid_o,
  input wire        forward_o,
  input wire [31:0] rewritten_address_o,
  input wire [15:0] rewritten_port_o,
  input wire        table_full_o
);

  // An accepted transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after accept");

  // A result is shown only once the block is free again.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy) else $error("result while busy");

  // Each result lasts exactly one cycle.
  a_result_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result held");

  // A forwarded packet never reports a full table.
  a_fwd_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(forward_o && table_full_o)) else $error("forward and full");

  // A dropped packet or tick carries an all-zero rewrite.
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !forward_o) |-> (rewritten_address_o == 32'd0 &&
                                        rewritten_port_o == 16'd0))
    else $error("dropped result not zero");

endmodule

bind nat_translation_table ntt_checker u_ntt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .result_valid_o     (result_valid_o),
  .forward_o          (forward_o),
  .rewritten_address_o(rewritten_address_o),
  .rewritten_port_o   (rewritten_port_o),
  .table_full_o       (table_full_o)
);

`default_nettype wire

>>> test/tb_top.sv
// Testbench for the NAT translation table: directed and random headers checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import ntt_pkg::*;

  localparam int NE = 16;
  localparam int NL = 4;
  localparam int NS = NE * NL;

  // One header or tick waiting to be driven.
  typedef struct {
    logic [1:0]  op;
    logic        outb;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  flags;
  } hdr_t;

  // One expected translation verdict.
  typedef struct {
    logic        fwd;
    logic [31:0] addr;
    logic [15:0] port;
    logic        full;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode_i = '0;
  logic outbound_i = 1'b0;
  logic [31:0] source_address_i = '0;
  logic [31:0] dest_address_i = '0;
  logic [15:0] source_port_i = '0;
  logic [15:0] dest_port_i = '0;
  logic [7:0] tcp_flag_bits_i = '0;
  logic result_valid_o;
  logic forward_o;
  logic [31:0] rewritten_address_o;
  logic [15:0] rewritten_port_o;
  logic table_full_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nat_translation_table dut (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .outbound_i, .source_address_i,
    .dest_address_i, .source_port_i, .dest_port_i, .tcp_flag_bits_i, .result_valid_o,
    .forward_o, .rewritten_address_o, .rewritten_port_o, .table_full_o, .psel, .penable,
    .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the register copies and the table shadow.
  logic [31:0] m_outer;
  logic [15:0] m_est, m_trn, m_icmp;
  logic [31:0] m_now, m_serial;
  logic        e_val[NE];
  logic        e_tcp[NE];
  logic [31:0] e_iaddr[NE];
  logic [15:0] e_iport[NE];
  logic [15:0] e_oport[NE];
  logic [31:0] e_stamp[NE];
  logic [31:0] e_ser[NE];
  logic        l_val[NS];
  logic [31:0] l_paddr[NS];
  logic [15:0] l_pport[NS];
  logic [2:0]  l_ph[NS];
  logic [31:0] l_stamp[NS];

  hdr_t     pending_hdrs[$];
  verdict_t verdicts_due[$];
  int       errors = 0;
  int       sender_idle_pct = 0;
  bit       stim_done = 0;
  bit       hold_send = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void drop_entry(input int e);
    e_val[e] = 1'b0;
    for (int k = 0; k < NL; k++) l_val[e*NL+k] = 1'b0;
  endfunction

  function automatic int live_links(input int e);
    int n;
    n = 0;
    for (int k = 0; k < NL; k++) if (l_val[e*NL+k]) n++;
    return n;
  endfunction

  // Newest matching entry, by inner tuple or by outer port.
  function automatic int lookup_entry(input logic tcp, input logic by_outer,
                                      input logic [31:0] a, input logic [15:0] p);
    int best;
    logic [31:0] best_age, age;
    logic hit;
    best = -1;
    best_age = '0;
    for (int e = 0; e < NE; e++) begin
      if (!e_val[e] || e_tcp[e] != tcp) continue;
      hit = by_outer ? (e_oport[e] == p) : (e_iaddr[e] == a && e_iport[e] == p);
      if (!hit) continue;
      age = m_serial - e_ser[e];
      if (best < 0 || age < best_age) begin
        best = e;
        best_age = age;
      end
    end
    return best;
  endfunction

  function automatic int free_slot();
    for (int e = 0; e < NE; e++) if (!e_val[e]) return e;
    return -1;
  endfunction

  function automatic int lookup_link(input int e, input logic [31:0] a, input logic [15:0] p,
                                     input logic want_free);
    int s;
    for (int k = 0; k < NL; k++) begin
      s = e * NL + k;
      if (want_free) begin
        if (!l_val[s]) return s;
      end else if (l_val[s] && l_paddr[s] == a && l_pport[s] == p) begin
        return s;
      end
    end
    return -1;
  endfunction

  function automatic void open_entry(input int e, input logic tcp, input logic [31:0] a,
                                     input logic [15:0] p);
    drop_entry(e);
    e_val[e] = 1'b1;
    e_tcp[e] = tcp;
    e_iaddr[e] = a;
    e_iport[e] = p;
    e_oport[e] = p;
    e_stamp[e] = m_now;
    e_ser[e] = m_serial;
    m_serial++;
  endfunction

  function automatic void open_link(input int s, input logic [31:0] a, input logic [15:0] p);
    l_val[s] = 1'b1;
    l_paddr[s] = a;
    l_pport[s] = p;
    l_ph[s] = PhSynSent;
    l_stamp[s] = m_now;
  endfunction

  function automatic void advance_phase(input int s, input logic [7:0] f, input logic outb);
    logic [2:0] ph;
    ph = l_ph[s];
    l_stamp[s] = m_now;
    if (f[FlagRst]) return;
    if (f[FlagFin]) begin
      l_ph[s] = PhClosing;
      return;
    end
    if (f[FlagSyn]) begin
      if (ph == PhEstab || ph == PhClosing) return;
      if (outb) begin
        if (ph != PhSynRcvd) l_ph[s] = PhSynSent;
      end else begin
        l_ph[s] = PhSynRcvd;
      end
      return;
    end
    if (ph == PhSynRcvd) l_ph[s] = PhEstab;
  endfunction

  function automatic void age_table();
    logic [31:0] lim;
    int s;
    m_now++;
    for (int e = 0; e < NE; e++) begin
      if (!e_val[e]) continue;
      if (e_tcp[e]) begin
        for (int k = 0; k < NL; k++) begin
          s = e * NL + k;
          if (!l_val[s]) continue;
          lim = (l_ph[s] == PhEstab) ? {16'd0, m_est} : {16'd0, m_trn};
          if (m_now - l_stamp[s] >= lim) l_val[s] = 1'b0;
        end
        if (live_links(e) == 0) drop_entry(e);
      end else if (m_now - e_stamp[e] >= {16'd0, m_icmp}) begin
        drop_entry(e);
      end
    end
  endfunction

  // Works out the verdict of one header and updates the shadow table.
  function automatic verdict_t translate(input hdr_t h);
    verdict_t v;
    int e, s, f;
    logic full;
    e = -1;
    full = 1'b0;
    if (h.op == OP_TICK) age_table();
    if (h.op == OP_ICMP) begin
      if (h.outb) begin
        e = lookup_entry(1'b0, 1'b0, h.saddr, h.sport);
        if (e < 0) begin
          f = free_slot();
          if (f < 0) full = 1'b1;
          else begin
            open_entry(f, 1'b0, h.saddr, h.sport);
            e = f;
          end
        end
      end else begin
        e = lookup_entry(1'b0, 1'b1, '0, h.sport);
      end
      if (e >= 0) e_stamp[e] = m_now;
    end else if (h.op == OP_TCP) begin
      e = h.outb ? lookup_entry(1'b1, 1'b0, h.saddr, h.sport)
                 : lookup_entry(1'b1, 1'b1, '0, h.dport);
      if (e >= 0) begin
        s = h.outb ? lookup_link(e, h.daddr, h.dport, 1'b0)
                   : lookup_link(e, h.saddr, h.sport, 1'b0);
        if (s < 0 && h.outb && h.flags[FlagSyn]) begin
          f = lookup_link(e, '0, '0, 1'b1);
          if (f < 0) begin
            full = 1'b1;
            e = -1;
          end else begin
            open_link(f, h.daddr, h.dport);
          end
        end else if (s >= 0) begin
          advance_phase(s, h.flags, h.outb);
        end
        if (e >= 0) e_stamp[e] = m_now;
      end else if (h.outb && h.flags[FlagSyn]) begin
        f = free_slot();
        if (f < 0) full = 1'b1;
        else begin
          open_entry(f, 1'b1, h.saddr, h.sport);
          e = f;
          open_link(e * NL, h.daddr, h.dport);
        end
      end
    end
    v.fwd = 1'b0;
    v.addr = '0;
    v.port = '0;
    v.full = full;
    if (e >= 0) begin
      v.fwd = 1'b1;
      if (h.outb) begin
        v.addr = m_outer;
        v.port = e_oport[e];
      end else begin
        v.addr = e_iaddr[e];
        v.port = e_iport[e];
      end
      if (e_tcp[e] && live_links(e) == 0) drop_entry(e);
    end
    return v;
  endfunction

  // Driver: one transaction at a time, with random sender gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        // The item at the queue head was just taken.
        verdicts_due.push_back(translate(pending_hdrs.pop_front()));
      end
      if ((start && !busy) || !start) begin
        if (pending_hdrs.size() > 0 && !hold_send &&
            $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          opcode_i <= pending_hdrs[0].op;
          outbound_i <= pending_hdrs[0].outb;
          source_address_i <= pending_hdrs[0].saddr;
          dest_address_i <= pending_hdrs[0].daddr;
          source_port_i <= pending_hdrs[0].sport;
          dest_port_i <= pending_hdrs[0].dport;
          tcp_flag_bits_i <= pending_hdrs[0].flags;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest verdict.
  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && result_valid_o) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("unexpected result", {31'd0, forward_o}, '0);
      end else begin
        v = verdicts_due.pop_front();
        if (forward_o !== v.fwd) report_mismatch("forward", {31'd0, forward_o}, {31'd0, v.fwd});
        if (rewritten_address_o !== v.addr) report_mismatch("address", rewritten_address_o, v.addr);
        if (rewritten_port_o !== v.port)
          report_mismatch("port", {16'd0, rewritten_port_o}, {16'd0, v.port});
        if (table_full_o !== v.full)
          report_mismatch("table_full", {31'd0, table_full_o}, {31'd0, v.full});
      end
    end
  end

  function automatic hdr_t mk(input logic [1:0] op, input logic outb, input logic [31:0] sa,
                              input logic [31:0] da, input logic [15:0] sp,
                              input logic [15:0] dp, input logic [7:0] fl);
    hdr_t h;
    h.op = op; h.outb = outb; h.saddr = sa; h.daddr = da;
    h.sport = sp; h.dport = dp; h.flags = fl;
    return h;
  endfunction

  // Waits until every queued item has gone in and every verdict has come back.
  task automatic drain();
    while (pending_hdrs.size() > 0 || verdicts_due.size() > 0 || start) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // APB write of one register, with the predictor copy updated at the same edge.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegOuterAddr:   m_outer = val;
      RegEstTimeout:  m_est = val[15:0];
      RegTrnTimeout:  m_trn = val[15:0];
      RegIcmpTimeout: m_icmp = val[15:0];
      default: ;
    endcase
  endtask

  // Random header: mostly well-formed flows over a small pool of hosts and ports.
  function automatic hdr_t rand_hdr();
    hdr_t h;
    logic [31:0] inner, peer;
    logic [15:0] ip, pp;
    int r;
    inner = 32'h0A00_0000 | $urandom_range(3);
    peer = 32'hC633_6400 | $urandom_range(3);
    ip = 16'd1000 + 16'($urandom_range(5));
    pp = 16'd80 + 16'($urandom_range(2));
    r = $urandom_range(99);
    if (r < 8) return mk(OP_TICK, 1'($urandom_range(1)), $urandom, $urandom,
                         16'($urandom), 16'($urandom), 8'($urandom));
    if (r < 10) return mk(2'd3, 1'($urandom_range(1)), $urandom, $urandom,
                          16'($urandom), 16'($urandom), 8'($urandom));
    if (r < 15) return mk(2'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom,
                          16'($urandom), 16'($urandom), 8'($urandom));
    if (r < 35) begin
      if ($urandom_range(1)) return mk(OP_ICMP, 1'b1, inner, peer, ip, 16'($urandom),
                                       8'($urandom));
      return mk(OP_ICMP, 1'b0, peer, m_outer, ip, 16'($urandom), 8'($urandom));
    end
    h.op = OP_TCP;
    h.flags = {5'($urandom_range(31)), 3'b000};
    case ($urandom_range(5))
      0, 1: h.flags[2:0] = 3'b010;
      2: h.flags[2:0] = 3'b000;
      3: h.flags[2:0] = 3'b001;
      4: h.flags[2:0] = 3'b100;
      default: h.flags[2:0] = 3'($urandom_range(7));
    endcase
    h.outb = 1'($urandom_range(1));
    if (h.outb) begin
      h.saddr = inner; h.sport = ip; h.daddr = peer; h.dport = pp;
    end else begin
      h.saddr = peer; h.sport = pp; h.daddr = m_outer; h.dport = ip;
    end
    return h;
  endfunction

  // Random headers of one phase while the sender is held at a given idle rate.
  task automatic random_phase(input int n, input int idle_pct);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < n; i++) begin
      pending_hdrs.push_back(rand_hdr());
      while (pending_hdrs.size() > 4) @(posedge clk_i);
    end
    drain();
  endtask

  initial begin
    m_outer = OuterAddrRst; m_est = EstTimeoutRst; m_trn = TrnTimeoutRst;
    m_icmp = IcmpTimeoutRst; m_now = '0; m_serial = '0;
    for (int e = 0; e < NE; e++) e_val[e] = 1'b0;
    for (int s = 0; s < NS; s++) l_val[s] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a full TCP handshake, inbound hits, flag priority, ICMP, extremes.
    pending_hdrs.push_back(mk(OP_TCP, 1'b1, 32'h0A000001, 32'h08080808, 16'd5000, 16'd80, 8'h02));
    pending_hdrs.push_back(mk(OP_TCP, 1'b0, 32'h08080808, 32'h0, 16'd80, 16'd5000, 8'h02));
    pending_hdrs.push_back(mk(OP_TCP, 1'b1, 32'h0A000001, 32'h08080808, 16'd5000, 16'd80, 8'h00));
    pending_hdrs.push_back(mk(OP_TCP, 1'b0, 32'h08080808, 32'h0, 16'd80, 16'd5000, 8'h07));
    pending_hdrs.push_back(mk(OP_TCP, 1'b0, 32'h08080808, 32'h0, 16'd80, 16'd5000, 8'h01));
    pending_hdrs.push_back(mk(OP_TCP, 1'b1, 32'h0A000001, 32'h08080808, 16'd5000, 16'd80, 8'h02));
    pending_hdrs.push_back(mk(OP_TCP, 1'b0, 32'h01010101, 32'h0, 16'd1, 16'd9, 8'h02));
    pending_hdrs.push_back(mk(OP_TCP, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 8'hFD));
    pending_hdrs.push_back(mk(OP_ICMP, 1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0));
    pending_hdrs.push_back(mk(OP_ICMP, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    pending_hdrs.push_back(mk(OP_ICMP, 1'b0, 32'h1, 32'h2, 16'hFFFF, 16'h0, 8'h0));
    pending_hdrs.push_back(mk(OP_ICMP, 1'b0, 32'h1, 32'h2, 16'h1234, 16'h0, 8'h0));
    pending_hdrs.push_back(mk(2'd3, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    pending_hdrs.push_back(mk(OP_TICK, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0));
    // Connection table of one entry overfilled, then the entry table overfilled.
    for (int k = 0; k < 5; k++)
      pending_hdrs.push_back(mk(OP_TCP, 1'b1, 32'h0A000002, 32'h09000000 + k, 16'd7, 16'd7, 8'h02));
    drain();
    for (int e = 0; e < 18; e++)
      pending_hdrs.push_back(mk(OP_ICMP, 1'b1, 32'h0B000000 + e, 32'h0, 16'(e), 16'h0, 8'h0));
    drain();

    // Zero timeouts clear everything at the next tick.
    reg_write(RegEstTimeout, 32'd0);
    reg_write(RegTrnTimeout, 32'd0);
    reg_write(RegIcmpTimeout, 32'd0);
    reg_write(RegOuterAddr, 32'hFFFFFFFF);
    pending_hdrs.push_back(mk(OP_TICK, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0));
    drain();

    // Short timeouts so that aging is exercised by the random ticks.
    reg_write(RegOuterAddr, 32'h0);
    reg_write(RegEstTimeout, 32'd6);
    reg_write(RegTrnTimeout, 32'd3);
    reg_write(RegIcmpTimeout, 32'd2);
    random_phase(230, 21);

    // The sender is held off while one header waits in the queue, then released.
    hold_send = 1'b1;
    pending_hdrs.push_back(rand_hdr());
    repeat (50) @(posedge clk_i);
    hold_send = 1'b0;
    drain();

    reg_write(RegOuterAddr, $urandom);
    reg_write(RegEstTimeout, 32'hFFFF);
    reg_write(RegTrnTimeout, 32'hFFFF);
    reg_write(RegIcmpTimeout, 32'hFFFF);
    random_phase(230, 87);

    reg_write(RegOuterAddr, $urandom);
    reg_write(RegEstTimeout, 32'd4);
    reg_write(RegTrnTimeout, 32'd1);
    reg_write(RegIcmpTimeout, 32'd1);
    random_phase(230, 0);

    if (errors == 0) $display("nat_translation_table verification clean");
    else $display("nat_translation_table verification failed");
    $finish;
  end

  // Watchdog: far above the slowest correct run.
  initial begin
    #20ms;
    $display("nat_translation_table verification failed");
    $finish;
  end

endmodule
